### src/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg
// shared constants, register index codes and pipeline flag types for the
// joystick axis calibration block
// ----------------------------------------------------------------------------
`default_nettype none

package jac_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int DEADZONE_RESET      = 80;
   localparam int CSR_INDEX_BITS      = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CALIBRATED  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_MIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_CENTER = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_MAX    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADZONE    = 3'd4;

   typedef struct packed {
      logic use_div;
      logic low_side;
      logic bad;
   } jac_flags_type;

endpackage

`default_nettype wire

### src/jac_front.sv
// ----------------------------------------------------------------------------
// jac_front
// two pipeline stages: sample differences and range checks, then path
// selection, deadzone test and divider operands
// ----------------------------------------------------------------------------
`default_nettype none

module jac_front #(
   parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                   cfg_calibrated,
   input  wire logic [SAMPLE_BITS-1:0] cfg_min,
   input  wire logic [SAMPLE_BITS-1:0] cfg_center,
   input  wire logic [SAMPLE_BITS-1:0] cfg_max,
   input  wire logic [SAMPLE_BITS-1:0] cfg_deadzone,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      jac_pkg::jac_flags_type out_flags,
   output      logic [SAMPLE_BITS-1:0] out_fixed,
   output      logic [SAMPLE_BITS-1:0] out_pos,
   output      logic [SAMPLE_BITS-1:0] out_span
);

   localparam int N = SAMPLE_BITS;
   localparam logic [N-1:0] MID = N'(1) << (N - 1);

   // stage 1
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_ready;
   logic [N-1:0]     s1_sample_ff;
   logic [N:0]       s1_dc_ff, s1_dc_in;
   logic [N:0]       s1_dm_ff, s1_dm_in;
   logic             s1_fall_ff, s1_fall_in;
   logic             s1_bad_ff, s1_bad_in;
   logic             s1_le_lo_ff, s1_le_lo_in;
   logic             s1_ge_hi_ff, s1_ge_hi_in;
   logic             s1_low_ff, s1_low_in;
   logic             s1_lo_ok_ff, s1_lo_ok_in;
   logic             s1_hi_ok_ff, s1_hi_ok_in;
   logic [N-1:0]     s1_span_lo_ff, s1_span_hi_ff;
   logic [N+1:0]     span_lo_full, span_hi_full;
   logic             ordered;

   // stage 2
   logic             s2_valid_ff;
   logic             s2_ready;
   jac_pkg::jac_flags_type s2_flags_ff, s2_flags_in;
   logic [N-1:0]     s2_fixed_ff, s2_fixed_in;
   logic [N-1:0]     s2_pos_ff, s2_pos_in;
   logic [N-1:0]     s2_span_ff, s2_span_in;
   logic [N-1:0]     abs_dc, abs_dm;
   logic             band_c, band_m;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign s1_valid_in = in_valid;

   always_comb begin
      ordered      = (cfg_min < cfg_center) && (cfg_center < cfg_max);
      s1_fall_in   = !cfg_calibrated || !ordered;
      s1_bad_in    = cfg_calibrated && !ordered;
      s1_dc_in     = {1'b0, in_sample} - {1'b0, cfg_center};
      s1_dm_in     = {1'b0, in_sample} - {1'b0, MID};
      s1_le_lo_in  = in_sample <= cfg_min;
      s1_ge_hi_in  = in_sample >= cfg_max;
      s1_low_in    = in_sample < cfg_center;
      span_lo_full = {2'b00, cfg_center} - {2'b00, cfg_min} - {2'b00, cfg_deadzone};
      span_hi_full = {2'b00, cfg_max} - {2'b00, cfg_center} - {2'b00, cfg_deadzone};
      s1_lo_ok_in  = !span_lo_full[N+1] && (span_lo_full != '0);
      s1_hi_ok_in  = !span_hi_full[N+1] && (span_hi_full != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_sample_ff  <= in_sample;
         s1_dc_ff      <= s1_dc_in;
         s1_dm_ff      <= s1_dm_in;
         s1_fall_ff    <= s1_fall_in;
         s1_bad_ff     <= s1_bad_in;
         s1_le_lo_ff   <= s1_le_lo_in;
         s1_ge_hi_ff   <= s1_ge_hi_in;
         s1_low_ff     <= s1_low_in;
         s1_lo_ok_ff   <= s1_lo_ok_in;
         s1_hi_ok_ff   <= s1_hi_ok_in;
         s1_span_lo_ff <= span_lo_full[N-1:0];
         s1_span_hi_ff <= span_hi_full[N-1:0];
      end
   end

   always_comb begin
      abs_dc = s1_dc_ff[N] ? N'(-s1_dc_ff) : s1_dc_ff[N-1:0];
      abs_dm = s1_dm_ff[N] ? N'(-s1_dm_ff) : s1_dm_ff[N-1:0];
      band_c = abs_dc < cfg_deadzone;
      band_m = abs_dm < cfg_deadzone;

      s2_flags_in.use_div  = 1'b0;
      s2_flags_in.low_side = s1_low_ff;
      s2_flags_in.bad      = s1_bad_ff;
      s2_fixed_in          = MID;
      s2_pos_in            = abs_dc - cfg_deadzone;
      s2_span_in           = s1_low_ff ? s1_span_lo_ff : s1_span_hi_ff;

      if (s1_fall_ff) begin
         s2_fixed_in = band_m ? MID : s1_sample_ff;
      end else if (band_c) begin
         s2_fixed_in = MID;
      end else if (s1_low_ff) begin
         if (s1_le_lo_ff) begin
            s2_fixed_in = '0;
         end else begin
            s2_flags_in.use_div = s1_lo_ok_ff;
         end
      end else begin
         if (s1_ge_hi_ff) begin
            s2_fixed_in = '1;
         end else begin
            s2_flags_in.use_div = s1_hi_ok_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_flags_ff <= s2_flags_in;
         s2_fixed_ff <= s2_fixed_in;
         s2_pos_ff   <= s2_pos_in;
         s2_span_ff  <= s2_span_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_flags = s2_flags_ff;
   assign out_fixed = s2_fixed_ff;
   assign out_pos   = s2_pos_ff;
   assign out_span  = s2_span_ff;

endmodule

`default_nettype wire

### src/jac_div.sv
// ----------------------------------------------------------------------------
// jac_div
// pipelined restoring divider: one stage forms pos * (mid - 1), then one
// quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module jac_div #(
   parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire jac_pkg::jac_flags_type in_flags,
   input  wire logic [SAMPLE_BITS-1:0] in_fixed,
   input  wire logic [SAMPLE_BITS-1:0] in_pos,
   input  wire logic [SAMPLE_BITS-1:0] in_span,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      jac_pkg::jac_flags_type out_flags,
   output      logic [SAMPLE_BITS-1:0] out_fixed,
   output      logic [SAMPLE_BITS-2:0] out_quot
);

   localparam int N     = SAMPLE_BITS;
   localparam int RW    = 2 * N - 1;
   localparam int DEPTH = N;

   logic                   valid_ff [DEPTH];
   logic                   rdy      [DEPTH];
   jac_pkg::jac_flags_type flags_ff [DEPTH];
   logic [N-1:0]           fixed_ff [DEPTH];
   logic [N-1:0]           span_ff  [DEPTH];
   logic [RW-1:0]          rem_ff   [DEPTH];
   logic [N-2:0]           quot_ff  [DEPTH];

   assign in_ready = rdy[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      if (i == DEPTH - 1) begin : g_last
         assign rdy[i] = !valid_ff[i] || out_ready;
      end else begin : g_mid
         assign rdy[i] = !valid_ff[i] || rdy[i+1];
      end

      if (i == 0) begin : g_num
         logic [RW-1:0] num;
         assign num = (RW'(in_pos) << (N - 1)) - RW'(in_pos);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (rdy[i]) begin
               valid_ff[i] <= in_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[i]) begin
               flags_ff[i] <= in_flags;
               fixed_ff[i] <= in_fixed;
               span_ff[i]  <= in_span;
               rem_ff[i]   <= num;
               quot_ff[i]  <= '0;
            end
         end
      end else begin : g_bit
         localparam int K = N - 1 - i;
         logic [RW-1:0] trial;
         logic          fits;
         logic [RW-1:0] rem_in;
         logic [N-2:0]  quot_in;

         always_comb begin
            trial      = RW'(span_ff[i-1]) << K;
            fits       = rem_ff[i-1] >= trial;
            rem_in     = fits ? rem_ff[i-1] - trial : rem_ff[i-1];
            quot_in    = quot_ff[i-1];
            quot_in[K] = fits;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (rdy[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end

         always_ff @(posedge clock) begin
            if (rdy[i]) begin
               flags_ff[i] <= flags_ff[i-1];
               fixed_ff[i] <= fixed_ff[i-1];
               span_ff[i]  <= span_ff[i-1];
               rem_ff[i]   <= rem_in;
               quot_ff[i]  <= quot_in;
            end
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_flags = flags_ff[DEPTH-1];
   assign out_fixed = fixed_ff[DEPTH-1];
   assign out_quot  = quot_ff[DEPTH-1];

endmodule

`default_nettype wire

### src/jac_out.sv
// ----------------------------------------------------------------------------
// jac_out
// output register: maps the quotient onto the low or high half of the
// output range, or passes the fixed value
// ----------------------------------------------------------------------------
`default_nettype none

module jac_out #(
   parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output      logic                   in_ready,
   input  wire jac_pkg::jac_flags_type in_flags,
   input  wire logic [SAMPLE_BITS-1:0] in_fixed,
   input  wire logic [SAMPLE_BITS-2:0] in_quot,
   output      logic                   out_valid,
   input  wire logic                   out_ready,
   output      logic [SAMPLE_BITS-1:0] out_value,
   output      logic                   out_invalid
);

   localparam int N = SAMPLE_BITS;
   localparam logic [N-1:0] MID      = N'(1) << (N - 1);
   localparam logic [N-1:0] HALFSPAN = MID - N'(1);

   logic         valid_ff;
   logic [N-1:0] value_ff, value_in;
   logic         invalid_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (!in_flags.use_div) begin
         value_in = in_fixed;
      end else if (in_flags.low_side) begin
         value_in = HALFSPAN - {1'b0, in_quot};
      end else begin
         value_in = MID + N'(1) + {1'b0, in_quot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         value_ff   <= value_in;
         invalid_ff <= in_flags.bad;
      end
   end

   assign out_valid   = valid_ff;
   assign out_value   = value_ff;
   assign out_invalid = invalid_ff;

endmodule

`default_nettype wire

### src/joystick_axis_calibrate.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrate
// throughput: one item per cycle unless the output stalls; the restoring
// divider gives one quotient bit per pipeline stage, so the stage count
// follows the sample width
// reset: clears all stage valid bits and loads the calibration registers
// with their defaults; csr writes are taken in every cycle
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_axis_calibrate #(
   parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [SAMPLE_BITS-1:0]             req_raw_sample,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [SAMPLE_BITS-1:0]             rsp_axis_value,
   output      logic                               rsp_config_invalid,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [jac_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SAMPLE_BITS-1:0]             csr_wdata
);

   localparam int N = SAMPLE_BITS;
   localparam logic [N-1:0] MID = N'(1) << (N - 1);

   logic         calibrated_ff;
   logic [N-1:0] axis_min_ff, axis_center_ff, axis_max_ff, deadzone_ff;

   logic                   f_valid, f_ready;
   jac_pkg::jac_flags_type f_flags;
   logic [N-1:0]           f_fixed, f_pos, f_span;

   logic                   d_valid, d_ready;
   jac_pkg::jac_flags_type d_flags;
   logic [N-1:0]           d_fixed;
   logic [N-2:0]           d_quot;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrated_ff  <= 1'b0;
         axis_min_ff    <= '0;
         axis_center_ff <= MID;
         axis_max_ff    <= '1;
         deadzone_ff    <= N'(jac_pkg::DEADZONE_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            jac_pkg::CSR_CALIBRATED:  calibrated_ff  <= csr_wdata[0];
            jac_pkg::CSR_AXIS_MIN:    axis_min_ff    <= csr_wdata;
            jac_pkg::CSR_AXIS_CENTER: axis_center_ff <= csr_wdata;
            jac_pkg::CSR_AXIS_MAX:    axis_max_ff    <= csr_wdata;
            jac_pkg::CSR_DEADZONE:    deadzone_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   jac_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_sample      (req_raw_sample),
      .cfg_calibrated (calibrated_ff),
      .cfg_min        (axis_min_ff),
      .cfg_center     (axis_center_ff),
      .cfg_max        (axis_max_ff),
      .cfg_deadzone   (deadzone_ff),
      .out_valid      (f_valid),
      .out_ready      (f_ready),
      .out_flags      (f_flags),
      .out_fixed      (f_fixed),
      .out_pos        (f_pos),
      .out_span       (f_span)
   );

   jac_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_flags  (f_flags),
      .in_fixed  (f_fixed),
      .in_pos    (f_pos),
      .in_span   (f_span),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_flags (d_flags),
      .out_fixed (d_fixed),
      .out_quot  (d_quot)
   );

   jac_out #(.SAMPLE_BITS(SAMPLE_BITS)) u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .in_flags    (d_flags),
      .in_fixed    (d_fixed),
      .in_quot     (d_quot),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_value   (rsp_axis_value),
      .out_invalid (rsp_config_invalid)
   );

endmodule

`default_nettype wire

### src/jac_checker.sv
// ----------------------------------------------------------------------------
// jac_checker
// port-level checks for joystick_axis_calibrate, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module jac_checker #(
   parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEFAULT
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] rsp_axis_value,
   input wire logic                   rsp_config_invalid,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input backs up only when the whole pipe is full behind a stalled result
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without an output stall");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_axis_value) && $stable(rsp_config_invalid)))
      else $error("stalled result changed");

   // csr writes never wait
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind joystick_axis_calibrate jac_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_axis_value     (rsp_axis_value),
   .rsp_config_invalid (rsp_config_invalid),
   .csr_valid          (csr_valid),
   .csr_ready          (csr_ready)
);

`default_nettype wire
